// ===== src/greedy_longest_match_segmenter_macros.svh =====
// assertion macros shared by the segmenter checker
// no dependencies; every macro expects clk and arst_n in scope
`ifndef GREEDY_LONGEST_MATCH_SEGMENTER_MACROS_SVH
`define GREEDY_LONGEST_MATCH_SEGMENTER_MACROS_SVH

// same-cycle implication, inactive during reset
`define GLM_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, inactive during reset
`define GLM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/glm_pkg.sv =====
// shared types and constants for the greedy longest-match segmenter
// no dependencies; imported by the cell, vocabulary memory, top level and checker
package glm_pkg;

	localparam int BYTE_W     = 8;
	localparam int TEXT_BYTES = 8;
	localparam int TEXT_W     = BYTE_W * TEXT_BYTES;
	localparam int LEN_W      = 4;

	// item function codes
	localparam logic FUNC_WRITE = 1'b0;
	localparam logic FUNC_CHAR  = 1'b1;

	// one vocabulary slot
	typedef struct packed {
		logic [LEN_W-1:0]  len;
		logic [TEXT_W-1:0] text;
	} vocab_entry_t;

	// control broadcast along the row of window cells
	typedef struct packed {
		logic             load;
		logic             shift;
		logic             clr;
		logic             cmp;
		logic [LEN_W-1:0] cnt;
		logic [LEN_W-1:0] top;
	} cell_ctl_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_CHECK,
		ST_SCAN,
		ST_FINISH,
		ST_DECIDE,
		ST_SHIFT
	} state_t;

endpackage

// ===== src/greedy_longest_match_segmenter.sv =====
// Greedy longest-match segmenter: splits words into vocabulary pieces.
// Input channel (in_valid/in_stall): func 0 writes vocabulary slot entry_index
// with entry_text/entry_length; func 1 delivers char_byte, word_last on the
// final character of a word. Output channel (out_valid/out_stall) carries one
// piece per transfer: piece_text, piece_length, ends_word, run_last (last piece
// caused by the input item). Configuration channel (cfg_valid/cfg_ready,
// cfg_data) sets the longest piece length tried; ready is always high.
// After reset the vocabulary lengths are cleared by a pass over all slots,
// during which in_stall is high; longest_piece resets to 8. For each emitted
// piece the vocabulary memory is scanned one slot per cycle through its
// single read port, then the window cells shift left one byte per cycle.
// Results sit in an output register; while the receiver stalls and a further
// piece is ready, the block waits before loading it. The next input item is
// accepted while the last result is still waiting.
module greedy_longest_match_segmenter #(
	parameter int MAX_PIECE   = 8,
	parameter int VOCAB_DEPTH = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        func,
	input  logic [7:0]  entry_index,
	input  logic [63:0] entry_text,
	input  logic [3:0]  entry_length,
	input  logic [7:0]  char_byte,
	input  logic        word_last,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] piece_text,
	output logic [3:0]  piece_length,
	output logic        ends_word,
	output logic        run_last,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [3:0]  cfg_data
);
	import glm_pkg::*;

	localparam int AW = (VOCAB_DEPTH > 1) ? $clog2(VOCAB_DEPTH) : 1;
	localparam logic [AW-1:0] LAST_ADDR = AW'(VOCAB_DEPTH - 1);

	state_t            state_q, state_d;
	logic [LEN_W-1:0]  count_q;
	logic              last_q;
	logic [AW-1:0]     scan_addr_q;
	logic              rd_vld_s1;
	logic [LEN_W-1:0]  shift_q;
	logic [LEN_W-1:0]  longest_piece_q;
	logic              out_valid_q;
	logic [TEXT_W-1:0] piece_text_q;
	logic [LEN_W-1:0]  piece_length_q;
	logic              ends_word_q;
	logic              run_last_q;

	logic [LEN_W-1:0]  lim;
	logic [LEN_W-1:0]  top;
	logic              go;
	logic              accept;
	logic              out_free;
	logic [LEN_W-1:0]  best;
	logic [LEN_W-1:0]  rem;
	logic              more;
	logic [TEXT_W-1:0] pick_text;
	logic [12:0]       idx_ext;

	logic              wr_en;
	logic [AW-1:0]     wr_addr;
	logic [LEN_W-1:0]  wr_len;
	logic [TEXT_W-1:0] wr_text;
	logic              rd_en;
	vocab_entry_t      rd_q;
	cell_ctl_t         ctl;

	logic [7:0]        win [MAX_PIECE];
	logic              eq_chain [MAX_PIECE+1];
	logic              flag [MAX_PIECE];

	// configuration register, always ready
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			longest_piece_q <= 4'd8;
		end else if (cfg_valid && cfg_ready) begin
			longest_piece_q <= cfg_data;
		end
	end

	// effective limit, saturated into 1..MAX_PIECE
	always_comb begin
		priority if (longest_piece_q == '0) begin
			lim = LEN_W'(1);
		end else if (longest_piece_q > LEN_W'(MAX_PIECE)) begin
			lim = LEN_W'(MAX_PIECE);
		end else begin
			lim = longest_piece_q;
		end
	end

	assign top      = (count_q < lim) ? count_q : lim;
	assign go       = (count_q >= lim) || (last_q && (count_q != '0));
	assign accept   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign idx_ext  = {5'd0, entry_index};

	// longest matched length, one character when nothing matched
	always_comb begin
		best = LEN_W'(1);
		for (int k = 0; k < MAX_PIECE; k++) begin
			if (flag[k]) begin
				best = LEN_W'(k + 1);
			end
		end
	end

	assign rem  = count_q - best;
	assign more = (rem >= lim) || (last_q && (rem != '0));

	// piece bytes from the head of the window, zero beyond its length
	always_comb begin
		pick_text = '0;
		for (int k = 0; k < MAX_PIECE; k++) begin
			if (LEN_W'(k) < best) begin
				pick_text[k*BYTE_W +: BYTE_W] = win[k];
			end
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR:  if (scan_addr_q == LAST_ADDR) state_d = ST_IDLE;
			ST_IDLE:   if (accept && (func == FUNC_CHAR)) state_d = ST_CHECK;
			ST_CHECK:  state_d = go ? ST_SCAN : ST_IDLE;
			ST_SCAN:   if (scan_addr_q == LAST_ADDR) state_d = ST_FINISH;
			ST_FINISH: state_d = ST_DECIDE;
			ST_DECIDE: if (out_free) state_d = ST_SHIFT;
			ST_SHIFT:  if (shift_q == LEN_W'(1)) state_d = ST_CHECK;
			default:   state_d = ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		in_stall  = (state_q != ST_IDLE);
		wr_en     = 1'b0;
		wr_addr   = scan_addr_q;
		wr_len    = '0;
		wr_text   = '0;
		rd_en     = 1'b0;
		ctl.load  = 1'b0;
		ctl.shift = 1'b0;
		ctl.clr   = 1'b0;
		ctl.cmp   = rd_vld_s1;
		ctl.cnt   = count_q;
		ctl.top   = top;
		unique case (state_q)
			ST_CLEAR: begin
				wr_en = 1'b1;
			end
			ST_IDLE: begin
				if (accept && (func == FUNC_WRITE)) begin
					wr_en   = (idx_ext < 13'(VOCAB_DEPTH));
					wr_addr = idx_ext[AW-1:0];
					wr_len  = entry_length;
					wr_text = entry_text;
				end
				ctl.load = accept && (func == FUNC_CHAR) && (count_q < LEN_W'(MAX_PIECE));
			end
			ST_CHECK:  ctl.clr = 1'b1;
			ST_SCAN:   rd_en = 1'b1;
			ST_SHIFT:  ctl.shift = 1'b1;
			default: ;
		endcase
	end

	// sequencer and window bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			count_q     <= '0;
			last_q      <= 1'b0;
			scan_addr_q <= '0;
			rd_vld_s1   <= 1'b0;
			shift_q     <= '0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= rd_en;
			if (state_q == ST_CHECK || scan_addr_q == LAST_ADDR) begin
				scan_addr_q <= '0;
			end else if (state_q == ST_CLEAR || state_q == ST_SCAN) begin
				scan_addr_q <= scan_addr_q + AW'(1);
			end
			if (ctl.load) begin
				count_q <= count_q + LEN_W'(1);
			end else if (state_q == ST_DECIDE && out_free) begin
				count_q <= rem;
			end
			if (state_q == ST_IDLE && accept && (func == FUNC_CHAR)) begin
				last_q <= word_last;
			end
			if (state_q == ST_DECIDE && out_free) begin
				shift_q <= best;
			end else if (state_q == ST_SHIFT) begin
				shift_q <= shift_q - LEN_W'(1);
			end
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DECIDE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (state_q == ST_DECIDE && out_free) begin
			piece_text_q   <= pick_text;
			piece_length_q <= best;
			ends_word_q    <= last_q && (rem == '0);
			run_last_q     <= !more;
		end
	end

	assign out_valid    = out_valid_q;
	assign piece_text   = piece_text_q;
	assign piece_length = piece_length_q;
	assign ends_word    = ends_word_q;
	assign run_last     = run_last_q;

	// vocabulary store
	glm_vocab_ram #(
		.DEPTH (VOCAB_DEPTH),
		.AW    (AW)
	) u_vocab (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_len  (wr_len),
		.wr_text (wr_text),
		.rd_en   (rd_en),
		.rd_addr (scan_addr_q),
		.rd_q    (rd_q)
	);

	// row of window cells
	assign eq_chain[0] = 1'b1;

	for (genvar k = 0; k < MAX_PIECE; k++) begin : g_cell
		logic [7:0] nb;
		if (k == MAX_PIECE - 1) begin : g_end
			assign nb = 8'd0;
		end else begin : g_mid
			assign nb = win[k+1];
		end
		glm_cell #(
			.IDX (k)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.char_in  (char_byte),
			.nb_in    (nb),
			.eq_in    (eq_chain[k]),
			.ent_byte (rd_q.text[k*BYTE_W +: BYTE_W]),
			.ent_len  (rd_q.len),
			.byte_q   (win[k]),
			.eq_out   (eq_chain[k+1]),
			.flag_q   (flag[k])
		);
	end

endmodule

// ===== src/glm_cell.sv =====
// one window cell: holds a buffered character and a sticky match flag
// depends on glm_pkg for the control struct and widths
module glm_cell #(
	parameter int IDX = 0
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  glm_pkg::cell_ctl_t      ctl,
	input  logic [7:0]              char_in,
	input  logic [7:0]              nb_in,
	input  logic                    eq_in,
	input  logic [7:0]              ent_byte,
	input  logic [3:0]              ent_len,
	output logic [7:0]              byte_q,
	output logic                    eq_out,
	output logic                    flag_q
);
	import glm_pkg::*;

	logic hit;

	// prefix equality runs from cell to cell
	assign eq_out = eq_in & (byte_q == ent_byte);

	// an entry of exactly this length, within the current try limit
	assign hit = eq_out && (ent_len == LEN_W'(IDX + 1)) && (LEN_W'(IDX + 1) <= ctl.top);

	// character storage: load at the fill position, or take the neighbour's byte
	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			byte_q <= nb_in;
		end else if (ctl.load && (ctl.cnt == LEN_W'(IDX))) begin
			byte_q <= char_in;
		end
	end

	// match flag for the running scan
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flag_q <= 1'b0;
		end else if (ctl.clr) begin
			flag_q <= 1'b0;
		end else if (ctl.cmp && hit) begin
			flag_q <= 1'b1;
		end
	end

endmodule

// ===== src/glm_vocab_ram.sv =====
// vocabulary memory: one write port, one registered read port
// depends on glm_pkg for the entry type and widths
module glm_vocab_ram #(
	parameter int DEPTH = 256,
	parameter int AW    = 8
) (
	input  logic                       clk,
	input  logic                       wr_en,
	input  logic [AW-1:0]              wr_addr,
	input  logic [3:0]                 wr_len,
	input  logic [63:0]                wr_text,
	input  logic                       rd_en,
	input  logic [AW-1:0]              rd_addr,
	output glm_pkg::vocab_entry_t      rd_q
);
	import glm_pkg::*;

	vocab_entry_t mem [DEPTH];
	logic [TEXT_W-1:0] masked_text;

	// bytes past the entry length are stored as zero
	always_comb begin
		masked_text = '0;
		for (int k = 0; k < TEXT_BYTES; k++) begin
			if (LEN_W'(k) < wr_len) begin
				masked_text[k*BYTE_W +: BYTE_W] = wr_text[k*BYTE_W +: BYTE_W];
			end
		end
	end

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= '{len: wr_len, text: masked_text};
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

endmodule

// ===== src/glm_checker.sv =====
// port-level checks for the greedy longest-match segmenter, bound to the top level
// depends on glm_pkg and greedy_longest_match_segmenter_macros.svh
`include "greedy_longest_match_segmenter_macros.svh"

module glm_checker #(
	parameter int MAX_PIECE = 8
) (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic       func,
	input logic       out_valid,
	input logic       out_stall,
	input logic [3:0] piece_length,
	input logic       ends_word,
	input logic       run_last
);
	import glm_pkg::*;

	// a stalled result stays offered
	`GLM_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result dropped while stalled")

	// piece lengths stay within the window size
	`GLM_ASSERT_NOW(a_len_range, out_valid, (piece_length != 4'd0) && (piece_length <= 4'(MAX_PIECE)), "piece length out of range")

	// the final piece of a word always closes the run of its item
	`GLM_ASSERT_NOW(a_end_run, out_valid && ends_word, run_last, "word end without run end")

	// a vocabulary write never holds up the next item
	`GLM_ASSERT_NEXT(a_write_free, in_valid && !in_stall && (func == FUNC_WRITE), !in_stall, "stall after vocabulary write")

endmodule

bind greedy_longest_match_segmenter glm_checker #(.MAX_PIECE(MAX_PIECE)) u_glm_checker (.*);
